// ----- sv/m31alu_pkg.sv -----
// ----------------------------------------------------------------------------
// m31alu_pkg
// Shared types, constants and the Mersenne fold for the GF(2^31-1) ALU.
// ----------------------------------------------------------------------------
package m31alu_pkg;

    localparam int unsigned ElemW = 31;
    localparam int unsigned ExpW  = 32;
    localparam int unsigned ProdW = 2 * ElemW;

    localparam logic [ElemW-1:0] FIELD_P   = '1;
    localparam logic [ExpW-1:0]  FERMAT_EXP = {1'b0, FIELD_P} - 32'd2;
    localparam logic [ElemW-1:0] FIELD_ONE = 31'd1;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_POW = 3'd3,
        CMD_INV = 3'd4
    } cmd_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL_FOLD,
        ST_BIT,
        ST_SQ,
        ST_FOLD_BASE,
        ST_DONE
    } state_e;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [ElemW-1:0] operand_a;
        logic [ExpW-1:0]  operand_b;
    } req_word_t;

    typedef struct packed {
        logic [ElemW-1:0] result;
        logic             error;
    } rsp_word_t;

    // Two folds of the high half into the low half, then one conditional subtract.
    function automatic logic [ElemW-1:0] fold_reduce(input logic [ProdW-1:0] x);
        logic [ElemW:0] s1;
        logic [ElemW:0] s2;
        s1 = {1'b0, x[ElemW-1:0]} + {1'b0, x[ProdW-1:ElemW]};
        s2 = {1'b0, s1[ElemW-1:0]} + {{ElemW{1'b0}}, s1[ElemW]};
        if (s2 >= {1'b0, FIELD_P})
        begin
            s2 = s2 - {1'b0, FIELD_P};
        end
        return s2[ElemW-1:0];
    endfunction

endpackage

// ----- sv/mersenne31_field_alu_unit.sv -----
// ----------------------------------------------------------------------------
// mersenne31_field_alu_unit
// Add, subtract, multiply, power and inverse modulo 2^31-1 on one multiplier.
// ----------------------------------------------------------------------------
//
//  port group  | dir | word type   | meaning
//  ------------+-----+-------------+---------------------------------------
//  req_*       | in  | req_word_t  | command, base/first operand, exponent/second operand
//  rsp_*       | out | rsp_word_t  | reduced result and inverse-of-zero flag
//
// Steps: accept, a dispatch state, then add/sub finish at once, multiply
// takes an extra fold state, power/inverse run square-and-multiply over the
// exponent: ST_BIT, ST_SQ and ST_FOLD_BASE for a set bit, ST_BIT and
// ST_FOLD_BASE for a clear bit, until the remaining exponent is zero. The one
// 31x31 multiplier with its registered product, folded the cycle after,
// sets that pace.
// Reset clears the sequencer and the output valid; no clearing pass.
// A new word is taken only in idle; a finished result waiting on the output
// register does not block the next request, only the next hand-off.
// ----------------------------------------------------------------------------
module mersenne31_field_alu_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  m31alu_pkg::req_word_t  req_word,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output m31alu_pkg::rsp_word_t  rsp_word
);
    import m31alu_pkg::*;

    // control
    state_e state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // datapath
    logic [2:0]       cmd_reg,  cmd_next;
    logic [ElemW-1:0] base_reg, base_next;   // reduced a, squared each bit
    logic [ElemW-1:0] b_reg,    b_next;      // reduced b
    logic [ExpW-1:0]  ex_reg,   ex_next;     // remaining exponent
    logic [ElemW-1:0] acc_reg,  acc_next;
    logic             err_reg,  err_next;
    logic [ProdW-1:0] prod_reg;
    rsp_word_t        out_reg,  out_next;

    // shared multiplier operands
    logic [ElemW-1:0] mul_x;
    logic [ElemW-1:0] mul_y;
    logic [ElemW-1:0] prod_fold;

    // input reduction and add/sub results
    logic [ElemW-1:0] a_red;
    logic [ElemW-1:0] b_red;
    logic [ElemW:0]   sum_ab;
    logic [ElemW:0]   diff_ab;
    logic             req_fire;
    logic             rsp_free;

    assign req_fire  = req_valid & req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;
    assign rsp_free  = !out_valid_reg || rsp_ready;

    assign a_red     = fold_reduce({{ElemW{1'b0}}, req_word.operand_a});
    assign b_red     = fold_reduce({{(ProdW-ExpW){1'b0}}, req_word.operand_b});
    assign prod_fold = fold_reduce(prod_reg);

    assign sum_ab  = {1'b0, base_reg} + {1'b0, b_reg};
    // a >= b: a - b; otherwise a + P - b, which stays below P
    assign diff_ab = (base_reg >= b_reg) ? ({1'b0, base_reg} - {1'b0, b_reg})
                                         : ({1'b0, base_reg} + {1'b0, FIELD_P}
                                            - {1'b0, b_reg});

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        base_next      = base_reg;
        b_next         = b_reg;
        ex_next        = ex_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        out_next       = out_reg;
        mul_x          = base_reg;
        mul_y          = base_reg;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next   = req_word.cmd;
                    base_next  = a_red;
                    b_next     = b_red;
                    ex_next    = (req_word.cmd == CMD_INV) ? FERMAT_EXP
                                                           : req_word.operand_b;
                    acc_next   = FIELD_ONE;
                    err_next   = 1'b0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                mul_x = base_reg;
                mul_y = b_reg;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        acc_next   = fold_reduce({{(ProdW-ElemW-1){1'b0}}, sum_ab});
                        state_next = ST_DONE;
                    end
                    CMD_SUB:
                    begin
                        acc_next   = diff_ab[ElemW-1:0];
                        state_next = ST_DONE;
                    end
                    CMD_MUL:
                    begin
                        state_next = ST_MUL_FOLD;
                    end
                    CMD_POW:
                    begin
                        state_next = ST_BIT;
                    end
                    CMD_INV:
                    begin
                        if (base_reg == '0)
                        begin
                            acc_next   = '0;
                            err_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_BIT;
                        end
                    end
                    default:
                    begin
                        // unused codes give zero, no error
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_MUL_FOLD:
            begin
                acc_next   = prod_fold;
                state_next = ST_DONE;
            end

            ST_BIT:
            begin
                if (ex_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (ex_reg[0])
                begin
                    mul_x      = acc_reg;
                    mul_y      = base_reg;
                    state_next = ST_SQ;
                end
                else
                begin
                    state_next = ST_FOLD_BASE;
                end
            end

            ST_SQ:
            begin
                // square issues while the acc product folds
                acc_next   = prod_fold;
                state_next = ST_FOLD_BASE;
            end

            ST_FOLD_BASE:
            begin
                base_next  = prod_fold;
                ex_next    = ex_reg >> 1;
                state_next = ST_BIT;
            end

            ST_DONE:
            begin
                if (rsp_free)
                begin
                    out_next.result = acc_reg;
                    out_next.error  = err_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        base_reg <= base_next;
        b_reg    <= b_next;
        ex_reg   <= ex_next;
        acc_reg  <= acc_next;
        err_reg  <= err_next;
        out_reg  <= out_next;
        prod_reg <= {{ElemW{1'b0}}, mul_x} * {{ElemW{1'b0}}, mul_y};
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.error |-> rsp_word.result == '0)
        else $error("error flagged with nonzero result");

    a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_word.result != FIELD_P)
        else $error("result not reduced");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == ST_EXEC)
        else $error("accepted word not dispatched");

    a_fold_ex: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FOLD_BASE |-> ex_reg != '0)
        else $error("squaring with exhausted exponent");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_valid_reg && !rsp_ready |=> state_reg == ST_DONE)
        else $error("result dropped on busy output");

endmodule
